FILE: rtl/core/svrm_pkg.sv
`default_nettype none
package svrm_pkg;

  typedef enum logic [2:0] {
    OP_PUSH  = 3'd0,
    OP_TICK  = 3'd1,
    OP_PLAY  = 3'd2,
    OP_PAUSE = 3'd3,
    OP_STOP  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNDERRUN = 2'd1,
    ST_DROPPED  = 2'd2,
    ST_IDLE     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    REG_STEP   = 3'd0,
    REG_LGAIN  = 3'd1,
    REG_RGAIN  = 3'd2,
    REG_MGAIN  = 3'd3,
    REG_LOOP   = 3'd4,
    REG_LENGTH = 3'd5
  } reg_e;

  typedef enum logic [1:0] {
    PS_STOPPED = 2'd0,
    PS_PLAYING = 2'd1,
    PS_PAUSED  = 2'd2
  } play_e;

  typedef enum logic [2:0] {
    BK_IDLE  = 3'd0,
    BK_READ  = 3'd1,
    BK_INTERP = 3'd2,
    BK_GAIN  = 3'd3,
    BK_MASTER = 3'd4,
    BK_OUT   = 3'd5
  } back_e;

  localparam int unsigned SampleW = 16;
  localparam int unsigned GainW   = 16;
  localparam int unsigned LenW    = 24;
  localparam int unsigned FrameW  = 32;

  // Request handed from the front to the back part.
  typedef struct packed {
    logic               tick;      // 1: interpolating tick, 0: plain result
    logic [1:0]         status;
    logic               playing;
  } req_t;

  function automatic logic signed [SampleW-1:0] clamp16(input logic signed [47:0] x);
    if (x < -48'sd32768) begin
      return 16'sh8000;
    end else if (x > 48'sd32767) begin
      return 16'sd32767;
    end
    return x[SampleW-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/svrm_front.sv
`default_nettype none
// Front part: control state, ring writes, tick classification.
module svrm_front #(
  parameter int unsigned FRAC_BITS   = 12,
  parameter int unsigned RING_FRAMES = 256,
  localparam int unsigned AW = $clog2(RING_FRAMES)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push_i,
  output logic                             full_o,
  input  wire logic [2:0]                  op_i,
  input  wire logic [svrm_pkg::SampleW-1:0] in_left_i,
  input  wire logic [svrm_pkg::SampleW-1:0] in_right_i,
  input  wire logic [15:0]                 step_rate_i,
  input  wire logic                        loop_enable_i,
  input  wire logic [svrm_pkg::LenW-1:0]   length_frames_i,
  input  wire logic                        q_full_i,
  output logic                             q_push_o,
  output svrm_pkg::req_t                   q_req_o,
  output logic [AW-1:0]                    q_a0_o,
  output logic [AW-1:0]                    q_a1_o,
  output logic [FRAC_BITS-1:0]             q_frac_o,
  output logic                             mem_we_o,
  output logic [AW-1:0]                    mem_wa_o,
  output logic [svrm_pkg::FrameW-1:0]      mem_wd_o
);
  import svrm_pkg::*;

  localparam int unsigned PosW = 32 + FRAC_BITS;

  logic [PosW-1:0] pos_q, pos_d;
  logic [31:0]     end_q, end_d, wr_q, wr_d;
  logic [AW-1:0]   slot_q, slot_d;
  play_e           ps_q, ps_d;
  logic            rew_q, rew_d;

  logic [PosW-1:0] pos_c;
  logic [31:0]     end_c, wr_c, beg, gap, gap1;
  logic [AW-1:0]   slot_c;
  logic [FRAC_BITS-1:0] frac;
  logic            acc;

  assign full_o = q_full_i;
  assign acc    = push_i && !q_full_i;

  always_comb begin
    // Pending rewind applies before a push or tick.
    pos_c  = pos_q;
    end_c  = end_q;
    wr_c   = wr_q;
    slot_c = slot_q;
    if (rew_q && (op_i == OP_PUSH || op_i == OP_TICK)) begin
      pos_c  = '0;
      end_c  = {8'd0, length_frames_i};
      wr_c   = '0;
      slot_c = '0;
    end
    beg   = pos_c[PosW-1:FRAC_BITS];
    frac  = pos_c[FRAC_BITS-1:0];
    gap   = wr_c - beg;
    gap1  = gap - 32'd1;

    pos_d  = pos_c;
    end_d  = end_c;
    wr_d   = wr_c;
    slot_d = slot_c;
    ps_d   = ps_q;
    rew_d  = rew_q && !(op_i == OP_PUSH || op_i == OP_TICK);
    q_req_o  = '{tick: 1'b0, status: ST_OK, playing: 1'b0};
    mem_we_o = 1'b0;
    mem_wa_o = slot_c;
    mem_wd_o = {in_right_i, in_left_i};
    q_a0_o   = slot_c - gap[AW-1:0];
    q_a1_o   = slot_c - gap1[AW-1:0];
    q_frac_o = frac;

    case (op_i)
      OP_PUSH: begin
        if (!gap[31] && gap >= 32'(RING_FRAMES)) begin
          q_req_o.status = ST_DROPPED;
        end else begin
          mem_we_o = 1'b1;
          slot_d   = slot_c + AW'(1);
          wr_d     = wr_c + 32'd1;
        end
      end
      OP_TICK: begin
        if (ps_q != PS_PLAYING) begin
          q_req_o.status = ST_IDLE;
        end else begin
          if (!(beg - end_c >= 32'h8000_0000)) begin
            end_d = beg + {8'd0, length_frames_i};
            if (!loop_enable_i) begin
              ps_d = PS_STOPPED;
              q_req_o.status = ST_IDLE;
            end
          end
          if (q_req_o.status == ST_OK) begin
            if (gap[31] || gap < ((frac != '0) ? 32'd2 : 32'd1)) begin
              q_req_o.status = ST_UNDERRUN;
            end else begin
              q_req_o.tick = 1'b1;
              pos_d = pos_c + PosW'(step_rate_i);
            end
          end
        end
      end
      OP_PLAY:  ps_d = PS_PLAYING;
      OP_PAUSE: ps_d = PS_PAUSED;
      OP_STOP: begin
        ps_d  = PS_STOPPED;
        rew_d = 1'b1;
      end
      default: ;
    endcase
    if (frac == '0) begin
      q_a1_o = q_a0_o;
    end
    q_req_o.playing = (ps_d == PS_PLAYING);
    mem_we_o = mem_we_o && acc;
    q_push_o = acc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      end_q  <= '0;
      wr_q   <= '0;
      slot_q <= '0;
      ps_q   <= PS_STOPPED;
      rew_q  <= 1'b1;
    end else if (acc) begin
      pos_q  <= pos_d;
      end_q  <= end_d;
      wr_q   <= wr_d;
      slot_q <= slot_d;
      ps_q   <= ps_d;
      rew_q  <= rew_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/svrm_back.sv
`default_nettype none
// Back part: ring read, interpolation, gain stages, one-entry output queue.
module svrm_back #(
  parameter int unsigned FRAC_BITS   = 12,
  parameter int unsigned RING_FRAMES = 256,
  localparam int unsigned AW = $clog2(RING_FRAMES)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  output logic                              q_full_o,
  input  wire logic                         q_push_i,
  input  wire svrm_pkg::req_t               q_req_i,
  input  wire logic [AW-1:0]                q_a0_i,
  input  wire logic [AW-1:0]                q_a1_i,
  input  wire logic [FRAC_BITS-1:0]         q_frac_i,
  input  wire logic                         mem_we_i,
  input  wire logic [AW-1:0]                mem_wa_i,
  input  wire logic [svrm_pkg::FrameW-1:0]  mem_wd_i,
  input  wire logic [svrm_pkg::GainW-1:0]   left_gain_i,
  input  wire logic [svrm_pkg::GainW-1:0]   right_gain_i,
  input  wire logic [svrm_pkg::GainW-1:0]   master_gain_i,
  output logic                              empty_o,
  input  wire logic                         pop_i,
  output logic [svrm_pkg::SampleW-1:0]      out_left_o,
  output logic [svrm_pkg::SampleW-1:0]      out_right_o,
  output logic [1:0]                        status_o,
  output logic                              is_playing_o
);
  import svrm_pkg::*;

  logic [FrameW-1:0] ring_q [RING_FRAMES];
  logic [FrameW-1:0] f0_q, f1_q;

  // Small request queue between front and back (two entries).
  req_t            rq_q [2];
  logic [AW-1:0]   a0_q [2], a1_q [2];
  logic [FRAC_BITS-1:0] fr_q [2];
  logic            mw_q [2];
  logic [AW-1:0]   wa_q [2];
  logic [FrameW-1:0] wd_q [2];
  logic            wp_q, rp_q;
  logic [1:0]      cnt_q;

  back_e st_q, st_d;
  req_t  cur_q;
  logic [FRAC_BITS-1:0] cf_q;
  logic signed [47:0] l_q, r_q;
  logic signed [47:0] l_d, r_d;

  logic ovalid_q;
  logic [SampleW-1:0] ol_q, or_q;
  logic [1:0] os_q;
  logic op_q;

  logic take, deq, ld_out;

  assign q_full_o = cnt_q[1];
  assign deq  = (st_q == BK_IDLE) && (cnt_q != 2'd0);
  assign take = ovalid_q && pop_i;
  assign empty_o = !ovalid_q;
  assign out_left_o = ol_q;
  assign out_right_o = or_q;
  assign status_o = os_q;
  assign is_playing_o = op_q;

  // Ring memory: a pushed frame is written when its request leaves the queue,
  // so every tick reads the ring exactly as its earlier requests left it.
  always_ff @(posedge clk_i) begin
    if (deq && mw_q[rp_q]) begin
      ring_q[wa_q[rp_q]] <= wd_q[rp_q];
    end
    if (st_q == BK_READ) begin
      f1_q <= ring_q[a1_q[rp_q ^ 1'b1]];
    end
    if (deq) begin
      f0_q <= ring_q[a0_q[rp_q]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_push_i) begin
      rq_q[wp_q] <= q_req_i;
      a0_q[wp_q] <= q_a0_i;
      a1_q[wp_q] <= q_a1_i;
      fr_q[wp_q] <= q_frac_i;
      mw_q[wp_q] <= mem_we_i;
      wa_q[wp_q] <= mem_wa_i;
      wd_q[wp_q] <= mem_wd_i;
    end
    if (deq) begin
      cur_q <= rq_q[rp_q];
      cf_q  <= fr_q[rp_q];
    end
    l_q <= l_d;
    r_q <= r_d;
  end

  // Datapath: one multiply per channel per step.
  always_comb begin
    logic signed [16:0] dl, dr;
    logic signed [47:0] pl, pr;
    l_d = l_q;
    r_d = r_q;
    dl = $signed({f1_q[15], f1_q[15:0]}) - $signed({f0_q[15], f0_q[15:0]});
    dr = $signed({f1_q[31], f1_q[31:16]}) - $signed({f0_q[31], f0_q[31:16]});
    pl = '0;
    pr = '0;
    case (st_q)
      BK_INTERP: begin
        pl = 48'(dl) * $signed({1'b0, cf_q});
        pr = 48'(dr) * $signed({1'b0, cf_q});
        l_d = 48'($signed(f0_q[15:0])) + (pl >>> FRAC_BITS);
        r_d = 48'($signed(f0_q[31:16])) + (pr >>> FRAC_BITS);
      end
      BK_GAIN: begin
        pl = l_q * $signed({32'd0, left_gain_i});
        pr = r_q * $signed({32'd0, right_gain_i});
        l_d = pl >>> FRAC_BITS;
        r_d = pr >>> FRAC_BITS;
      end
      BK_MASTER: begin
        pl = l_q * $signed({32'd0, master_gain_i});
        pr = r_q * $signed({32'd0, master_gain_i});
        l_d = pl >>> FRAC_BITS;
        r_d = pr >>> FRAC_BITS;
      end
      default: ;
    endcase
  end

  // Sequencer for the back part.
  always_comb begin
    st_d = st_q;
    ld_out = 1'b0;
    case (st_q)
      BK_IDLE:   if (deq) st_d = rq_q[rp_q].tick ? BK_READ : BK_OUT;
      BK_READ:   st_d = BK_INTERP;
      BK_INTERP: st_d = BK_GAIN;
      BK_GAIN:   st_d = BK_MASTER;
      BK_MASTER: st_d = BK_OUT;
      BK_OUT: begin
        if (!ovalid_q || take) begin
          ld_out = 1'b1;
          st_d = BK_IDLE;
        end
      end
      default:   st_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_IDLE;
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (q_push_i) wp_q <= ~wp_q;
      if (deq) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, q_push_i} - {1'b0, deq};
      if (ld_out) ovalid_q <= 1'b1;
      else if (take) ovalid_q <= 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (ld_out) begin
      ol_q <= cur_q.tick ? clamp16(l_q) : '0;
      or_q <= cur_q.tick ? clamp16(r_q) : '0;
      os_q <= cur_q.status;
      op_q <= cur_q.playing;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/stereo_voice_resampler_mixer_core.sv
`default_nettype none
// A request goes from the two-entry queue into the back part: push and
// events go straight to BK_OUT; an interpolating tick first runs BK_READ
// and the back part's three chained multiply steps. BK_OUT waits on the
// output register, and a new request starts only from BK_IDLE.
// Reset clears control state and configuration registers; ring contents stay undefined.
module stereo_voice_resampler_mixer_core #(
  parameter int unsigned FRAC_BITS   = 12,
  parameter int unsigned RING_FRAMES = 256
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [2:0]                  op_i,
  input  wire logic [15:0]                 in_left_i,
  input  wire logic [15:0]                 in_right_i,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [15:0]                      out_left_o,
  output logic [15:0]                      out_right_o,
  output logic [1:0]                       status_o,
  output logic                             is_playing_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [2:0]                  cfg_index_i,
  input  wire logic [23:0]                 cfg_data_i
);
  import svrm_pkg::*;

  localparam int unsigned AW = $clog2(RING_FRAMES);

  logic [15:0] step_q, lg_q, rg_q, mg_q;
  logic        loop_q;
  logic [23:0] len_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 16'd4096;
      lg_q   <= 16'd4096;
      rg_q   <= 16'd4096;
      mg_q   <= 16'd4096;
      loop_q <= 1'b0;
      len_q  <= 24'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_STEP:   step_q <= cfg_data_i[15:0];
        REG_LGAIN:  lg_q   <= cfg_data_i[15:0];
        REG_RGAIN:  rg_q   <= cfg_data_i[15:0];
        REG_MGAIN:  mg_q   <= cfg_data_i[15:0];
        REG_LOOP:   loop_q <= cfg_data_i[0];
        REG_LENGTH: len_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic q_full, q_push, mem_we;
  req_t q_req;
  logic [AW-1:0] a0, a1, wa;
  logic [FRAC_BITS-1:0] fr;
  logic [31:0] wd;

  svrm_front #(.FRAC_BITS(FRAC_BITS), .RING_FRAMES(RING_FRAMES)) u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .op_i, .in_left_i, .in_right_i,
    .step_rate_i(step_q), .loop_enable_i(loop_q), .length_frames_i(len_q),
    .q_full_i(q_full), .q_push_o(q_push), .q_req_o(q_req), .q_a0_o(a0),
    .q_a1_o(a1), .q_frac_o(fr), .mem_we_o(mem_we), .mem_wa_o(wa), .mem_wd_o(wd)
  );

  svrm_back #(.FRAC_BITS(FRAC_BITS), .RING_FRAMES(RING_FRAMES)) u_back (
    .clk_i, .rst_ni, .q_full_o(q_full), .q_push_i(q_push), .q_req_i(q_req),
    .q_a0_i(a0), .q_a1_i(a1), .q_frac_i(fr), .mem_we_i(mem_we), .mem_wa_i(wa),
    .mem_wd_i(wd), .left_gain_i(lg_q), .right_gain_i(rg_q), .master_gain_i(mg_q),
    .empty_o(empty), .pop_i(pop), .out_left_o, .out_right_o, .status_o, .is_playing_o
  );

endmodule
`default_nettype wire
